// ----- sv/slrd_pkg.sv -----
`timescale 1ns / 1ps

package slrd_pkg;

    // configuration
    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_TELNET = 2'd2;
    localparam logic [1:0] MODE_RESET  = MODE_ESCAPE;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // protocol bytes
    localparam logic [7:0] BYTE_IAC  = 8'hFF;
    localparam logic [7:0] CMD_GA    = 8'd249;
    localparam logic [7:0] CMD_SB    = 8'd250;
    localparam logic [7:0] CMD_WILL  = 8'd251;
    localparam logic [7:0] CMD_WONT  = 8'd252;
    localparam logic [7:0] CMD_DO    = 8'd253;
    localparam logic [7:0] CMD_DONT  = 8'd254;
    localparam logic [7:0] OPT_BIN   = 8'd0;
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;

    // line status bits
    localparam int ST_CTS_BIT = 0;
    localparam int ST_DSR_BIT = 1;
    localparam int ST_BRK_BIT = 2;

    // option flag bits
    localparam int FLAG_W      = 6;
    localparam int F_BIN_S_BIT  = 0;
    localparam int F_ECHO_S_BIT = 1;
    localparam int F_SGA_S_BIT  = 2;
    localparam int F_BIN_C_BIT  = 3;
    localparam int F_ECHO_C_BIT = 4;
    localparam int F_SGA_C_BIT  = 5;

    // default queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // what the back end has to send for one request
    typedef enum logic [1:0] {
        OP_SINGLE   = 2'd0,
        OP_STAT_BRK = 2'd1,
        OP_REPLY    = 2'd2
    } t_job_op;

    typedef struct packed {
        t_job_op    op;
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] verb;
        logic       cts;
        logic       dsr;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- sv/slrd_front.sv -----
`timescale 1ns / 1ps

module slrd_front
    import slrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0]        r_rx_mode;
    logic              r_escape_pending, n_escape_pending;
    logic              r_in_iac, n_in_iac;
    logic              r_have_command, n_have_command;
    logic [7:0]        r_command_byte, n_command_byte;
    logic [FLAG_W-1:0] r_option_flags, n_option_flags;
    logic              accept;
    logic              emit;
    logic              known;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign o_push  = accept && emit;
    assign known   = (i_rx_byte == OPT_BIN) || (i_rx_byte == OPT_ECHO)
                  || (i_rx_byte == OPT_SGA);

    // classify the byte and work out the next decoder state
    always_comb begin
        n_escape_pending = r_escape_pending;
        n_in_iac         = r_in_iac;
        n_have_command   = r_have_command;
        n_command_byte   = r_command_byte;
        n_option_flags   = r_option_flags;
        emit             = 1'b0;
        o_job.op         = OP_SINGLE;
        o_job.kind       = KIND_PAYLOAD;
        o_job.data       = i_rx_byte;
        o_job.verb       = CMD_WONT;
        o_job.cts        = 1'b0;
        o_job.dsr        = 1'b0;
        if (r_rx_mode == MODE_TELNET) begin
            if (!r_in_iac) begin
                if (i_rx_byte == BYTE_IAC) begin
                    n_in_iac = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end else if (!r_have_command) begin
                if (i_rx_byte == CMD_GA) begin
                    n_in_iac = 1'b0;
                end else begin
                    n_command_byte = i_rx_byte;
                    n_have_command = 1'b1;
                    // doubled escape in binary mode is a literal byte
                    if (r_option_flags[F_BIN_S_BIT] && i_rx_byte == BYTE_IAC) begin
                        n_in_iac       = 1'b0;
                        n_have_command = 1'b0;
                        emit           = 1'b1;
                    end
                end
            end else begin
                // option byte of a held command
                n_in_iac       = 1'b0;
                n_have_command = 1'b0;
                o_job.op       = OP_REPLY;
                if (!known && r_command_byte > CMD_SB) begin
                    emit       = 1'b1;
                    o_job.verb = CMD_WONT;
                end
                if (r_command_byte == CMD_WILL || r_command_byte == CMD_WONT) begin
                    if (i_rx_byte == OPT_BIN)
                        n_option_flags[F_BIN_S_BIT] = (r_command_byte == CMD_WILL);
                    if (i_rx_byte == OPT_ECHO)
                        n_option_flags[F_ECHO_S_BIT] = (r_command_byte == CMD_WILL);
                    if (i_rx_byte == OPT_SGA)
                        n_option_flags[F_SGA_S_BIT] = (r_command_byte == CMD_WILL);
                end else if (r_command_byte == CMD_DO || r_command_byte == CMD_DONT) begin
                    if (i_rx_byte == OPT_BIN) begin
                        n_option_flags[F_BIN_C_BIT] = (r_command_byte == CMD_DO);
                        emit       = 1'b1;
                        o_job.verb = (r_command_byte == CMD_DO) ? CMD_WILL : CMD_WONT;
                    end
                    if (i_rx_byte == OPT_ECHO) begin
                        n_option_flags[F_ECHO_C_BIT] = 1'b0;
                        emit       = 1'b1;
                        o_job.verb = CMD_WONT;
                    end
                    if (i_rx_byte == OPT_SGA) begin
                        n_option_flags[F_SGA_C_BIT] = 1'b1;
                        emit       = 1'b1;
                        o_job.verb = CMD_WILL;
                    end
                end
            end
        end else if (r_rx_mode == MODE_ESCAPE) begin
            if (!r_escape_pending) begin
                if (i_rx_byte == BYTE_IAC) begin
                    n_escape_pending = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end else begin
                n_escape_pending = 1'b0;
                emit             = 1'b1;
                if (i_rx_byte != BYTE_IAC) begin
                    // line status word
                    o_job.kind = KIND_STATUS;
                    o_job.data = 8'd0;
                    o_job.cts  = i_rx_byte[ST_CTS_BIT];
                    o_job.dsr  = i_rx_byte[ST_DSR_BIT];
                    if (i_rx_byte[ST_BRK_BIT])
                        o_job.op = OP_STAT_BRK;
                end
            end
        end else begin
            emit = 1'b1;
        end
    end

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_rx_mode <= i_cfg_data;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_pending <= 1'b0;
            r_in_iac         <= 1'b0;
            r_have_command   <= 1'b0;
            r_command_byte   <= 8'd0;
            r_option_flags   <= '0;
        end else if (accept) begin
            r_escape_pending <= n_escape_pending;
            r_in_iac         <= n_in_iac;
            r_have_command   <= n_have_command;
            r_command_byte   <= n_command_byte;
            r_option_flags   <= n_option_flags;
        end
    end

endmodule

// ----- sv/slrd_queue.sv -----
`timescale 1ns / 1ps

module slrd_queue
    import slrd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_entry[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push)
            r_entry[r_wr_ptr] <= i_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            if (do_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            if (do_push && !do_pop)
                r_count <= r_count + 1'b1;
            else if (do_pop && !do_push)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

// ----- sv/slrd_back.sv -----
`timescale 1ns / 1ps

module slrd_back
    import slrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_break_flag,
    output logic       o_cts_level,
    output logic       o_dsr_level,
    output logic       o_last
);

    logic       r_valid;
    logic [1:0] r_step;
    logic [1:0] r_kind,  n_kind;
    logic [7:0] r_byte,  n_byte;
    logic       r_brk,   n_brk;
    logic       r_cts,   n_cts;
    logic       r_dsr,   n_dsr;
    logic       r_last,  n_last;
    logic       load;

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && !i_q_status.empty && n_last;

    // expand the head request into the result of the current step
    always_comb begin
        n_kind = i_head.kind;
        n_byte = i_head.data;
        n_brk  = 1'b0;
        n_cts  = i_head.cts;
        n_dsr  = i_head.dsr;
        n_last = 1'b1;
        unique case (i_head.op)
            OP_SINGLE: begin
                n_last = 1'b1;
            end
            OP_STAT_BRK: begin
                if (r_step == 2'd0) begin
                    n_last = 1'b0;
                end else begin
                    // break payload after the status word
                    n_kind = KIND_PAYLOAD;
                    n_byte = 8'd0;
                    n_brk  = 1'b1;
                    n_cts  = 1'b0;
                    n_dsr  = 1'b0;
                end
            end
            OP_REPLY: begin
                n_kind = KIND_REPLY;
                n_cts  = 1'b0;
                n_dsr  = 1'b0;
                n_last = (r_step == 2'd2);
                if (r_step == 2'd0)
                    n_byte = BYTE_IAC;
                else if (r_step == 2'd1)
                    n_byte = i_head.verb;
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else if (load) begin
            r_valid <= !i_q_status.empty;
            if (!i_q_status.empty)
                r_step <= n_last ? 2'd0 : r_step + 2'd1;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load && !i_q_status.empty) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_brk  <= n_brk;
            r_cts  <= n_cts;
            r_dsr  <= n_dsr;
            r_last <= n_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_kind   = r_kind;
    assign o_out_byte   = r_byte;
    assign o_break_flag = r_brk;
    assign o_cts_level  = r_cts;
    assign o_dsr_level  = r_dsr;
    assign o_last       = r_last;

endmodule

// ----- sv/serial_link_rx_decoder_unit.sv -----
`timescale 1ns / 1ps

// Receive-side decoder for bytes arriving from a network link.
// Input channel: i_valid / o_stall with i_rx_byte; a byte is taken at an edge
// with i_valid high and o_stall low. Output channel: o_valid / i_stall with
// kind, byte, break, cts, dsr and last; o_last marks the final result of a byte.
// Mode register (raw, escape, telnet) is written through i_cfg_we / i_cfg_data;
// the user must write it only while the block is idle, as the block does not
// enforce this. It comes out of reset in escape mode. The front end decodes
// each byte in the cycle it is taken and queues at most one request; the back
// end expands a request into one to three results. The first result of a byte
// passes through the request queue and then the back end's output register.
// Single-result bytes are taken one per cycle while the receiver does not
// stall; a status word with break yields two results and a telnet reply three,
// which the back end emits one per cycle from its output register unless stalled.
// Bytes that yield no result (escape and command prefixes) queue no request.
// Reset empties the queue, clears the output valid and all escape and telnet
// state with every option off. When the receiver stalls, the output holds; the
// request queue fills and then o_stall rises until space frees up.

module serial_link_rx_decoder_unit
    import slrd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_break_flag,
    output logic       o_cts_level,
    output logic       o_dsr_level,
    output logic       o_last
);

    t_q_status q_status;
    t_job      push_job;
    t_job      head_job;
    logic      push;
    logic      pop;

    // decode and classify
    slrd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_rx_byte  (i_rx_byte),
        .o_stall    (o_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // request queue
    slrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    // result sequencing
    slrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_break_flag (o_break_flag),
        .o_cts_level  (o_cts_level),
        .o_dsr_level  (o_dsr_level),
        .o_last       (o_last)
    );

    // queue cannot be full and empty at once
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // break result is always a zero payload byte closing its request
    a_break_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_break_flag) |->
        (o_out_kind == KIND_PAYLOAD && o_out_byte == 8'd0 && o_last))
        else $error("malformed break result");

    // line levels only on status results
    a_levels_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_cts_level || o_dsr_level)) |-> (o_out_kind == KIND_STATUS))
        else $error("line levels on a non-status result");

    // a status word that is not last is followed at once by its break
    a_status_then_break: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_out_kind == KIND_STATUS && !o_last) |=>
        (o_valid && o_break_flag))
        else $error("status word not followed by break");

endmodule

// ----- tb/slrd_decode_checker.sv -----
`timescale 1ns / 1ps

module slrd_decode_checker
    import slrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [1:0] i_out_kind,
    input  logic [7:0] i_out_byte,
    input  logic       i_break_flag,
    input  logic       i_cts_level,
    input  logic       i_dsr_level,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       brk;
        logic       cts;
        logic       dsr;
        logic       last;
    } t_link_result;

    // results still owed by the block, oldest first
    t_link_result owed_results[$];
    // results caused by the byte being decoded
    t_link_result byte_results[$];

    // decoder state as the block should hold it
    logic [1:0]        link_mode;
    logic              esc_wait;
    logic              iac_seen;
    logic              cmd_held;
    logic [7:0]        held_cmd;
    logic [FLAG_W-1:0] opt_flags;

    int fails   = 0;
    int checked = 0;
    int pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;

    task automatic add_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic brk, input logic cts, input logic dsr);
        t_link_result r;
        r.kind = kind;
        r.data = data;
        r.brk  = brk;
        r.cts  = cts;
        r.dsr  = dsr;
        r.last = 1'b0;
        byte_results.push_back(r);
    endtask

    task automatic add_reply(input logic [7:0] verb, input logic [7:0] opt);
        add_result(KIND_REPLY, BYTE_IAC, 1'b0, 1'b0, 1'b0);
        add_result(KIND_REPLY, verb, 1'b0, 1'b0, 1'b0);
        add_result(KIND_REPLY, opt, 1'b0, 1'b0, 1'b0);
    endtask

    // work out the results of one received byte and queue them
    task automatic decode_byte(input logic [7:0] b);
        logic         known;
        t_link_result tail;
        byte_results.delete();
        case (link_mode)
            MODE_TELNET: begin
                if (!iac_seen) begin
                    if (b == BYTE_IAC) iac_seen = 1'b1;
                    else add_result(KIND_PAYLOAD, b, 1'b0, 1'b0, 1'b0);
                end else if (!cmd_held) begin
                    held_cmd = b;
                    if (b == CMD_GA) begin
                        iac_seen = 1'b0;
                    end else if (opt_flags[F_BIN_S_BIT] && b == BYTE_IAC) begin
                        // binary mode: doubled iac is a data byte
                        iac_seen = 1'b0;
                        add_result(KIND_PAYLOAD, BYTE_IAC, 1'b0, 1'b0, 1'b0);
                    end else begin
                        cmd_held = 1'b1;
                    end
                end else begin
                    // option byte closes the sequence
                    known = (b == OPT_BIN) || (b == OPT_ECHO) || (b == OPT_SGA);
                    if (!known && held_cmd > CMD_SB) add_reply(CMD_WONT, b);
                    if (held_cmd == CMD_WILL || held_cmd == CMD_WONT) begin
                        if (b == OPT_BIN)  opt_flags[F_BIN_S_BIT]  = (held_cmd == CMD_WILL);
                        if (b == OPT_ECHO) opt_flags[F_ECHO_S_BIT] = (held_cmd == CMD_WILL);
                        if (b == OPT_SGA)  opt_flags[F_SGA_S_BIT]  = (held_cmd == CMD_WILL);
                    end else if (held_cmd == CMD_DO || held_cmd == CMD_DONT) begin
                        if (b == OPT_BIN) begin
                            opt_flags[F_BIN_C_BIT] = (held_cmd == CMD_DO);
                            add_reply((held_cmd == CMD_DO) ? CMD_WILL : CMD_WONT, OPT_BIN);
                        end
                        if (b == OPT_ECHO) begin
                            opt_flags[F_ECHO_C_BIT] = 1'b0;
                            add_reply(CMD_WONT, OPT_ECHO);
                        end
                        if (b == OPT_SGA) begin
                            opt_flags[F_SGA_C_BIT] = 1'b1;
                            add_reply(CMD_WILL, OPT_SGA);
                        end
                    end
                    iac_seen = 1'b0;
                    cmd_held = 1'b0;
                end
            end
            MODE_ESCAPE: begin
                if (!esc_wait) begin
                    if (b == BYTE_IAC) esc_wait = 1'b1;
                    else add_result(KIND_PAYLOAD, b, 1'b0, 1'b0, 1'b0);
                end else begin
                    esc_wait = 1'b0;
                    if (b == BYTE_IAC) begin
                        add_result(KIND_PAYLOAD, BYTE_IAC, 1'b0, 1'b0, 1'b0);
                    end else begin
                        add_result(KIND_STATUS, 8'd0, 1'b0, b[ST_CTS_BIT], b[ST_DSR_BIT]);
                        if (b[ST_BRK_BIT]) add_result(KIND_PAYLOAD, 8'd0, 1'b1, 1'b0, 1'b0);
                    end
                end
            end
            // raw and the spare mode pass bytes through
            default: add_result(KIND_PAYLOAD, b, 1'b0, 1'b0, 1'b0);
        endcase
        if (byte_results.size() > 0) begin
            tail = byte_results[byte_results.size() - 1];
            tail.last = 1'b1;
            byte_results[byte_results.size() - 1] = tail;
        end
        foreach (byte_results[i]) owed_results.push_back(byte_results[i]);
    endtask

    // watch both channels and the mode register
    always @(posedge i_clk) begin
        t_link_result got;
        t_link_result want;
        if (!i_rst_n) begin
            link_mode = MODE_RESET;
            esc_wait  = 1'b0;
            iac_seen  = 1'b0;
            cmd_held  = 1'b0;
            held_cmd  = 8'd0;
            opt_flags = '0;
            owed_results.delete();
        end else begin
            // compare an accepted result with the oldest owed one
            if (i_out_valid && !i_out_stall) begin
                got.kind = i_out_kind;
                got.data = i_out_byte;
                got.brk  = i_break_flag;
                got.cts  = i_cts_level;
                got.dsr  = i_dsr_level;
                got.last = i_last;
                if (owed_results.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("unexpected result at %0t: kind %0d byte %02h brk %0b cts %0b dsr %0b last %0b",
                                 $realtime, got.kind, got.data, got.brk, got.cts, got.dsr,
                                 got.last);
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("mismatch at %0t: kind %0d/%0d byte %02h/%02h brk %0b/%0b cts %0b/%0b dsr %0b/%0b last %0b/%0b (expected/actual)",
                                     $realtime, want.kind, got.kind, want.data, got.data,
                                     want.brk, got.brk, want.cts, got.cts, want.dsr, got.dsr,
                                     want.last, got.last);
                    end
                end
            end
            // accepted request
            if (i_in_valid && !i_in_stall) decode_byte(i_rx_byte);
            // mode register write
            if (i_cfg_we) link_mode = i_cfg_data;
        end
        pending = owed_results.size();
    end

endmodule

// ----- tb/serial_link_rx_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module serial_link_rx_decoder_unit_tb;
    import slrd_pkg::*;

    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         SETTLE_CYCLES   = 6;
    localparam int         HOLD_OFF_CYCLES = 150;
    localparam logic [1:0] MODE_SPARE      = 2'd3;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_data = MODE_RESET;
    logic       i_valid    = 1'b0;
    logic [7:0] i_rx_byte  = 8'd0;
    logic       i_stall    = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic       o_break_flag;
    logic       o_cts_level;
    logic       o_dsr_level;
    logic       o_last;

    int fail_count;
    int pending;
    int checked;
    int bytes_sent    = 0;
    int cycle_count   = 0;
    int tx_idle_pct   = 33;
    int rx_idle_pct   = 33;
    int hold_off_req  = 0;
    int hold_off_done = 0;

    serial_link_rx_decoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_break_flag (o_break_flag),
        .o_cts_level  (o_cts_level),
        .o_dsr_level  (o_dsr_level),
        .o_last       (o_last)
    );

    slrd_decode_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_kind   (o_out_kind),
        .i_out_byte   (o_out_byte),
        .i_break_flag (o_break_flag),
        .i_cts_level  (o_cts_level),
        .i_dsr_level  (o_dsr_level),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req != hold_off_done) begin
                hold_off_done = hold_off_req;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // offer one request, with an optional gap before it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // stop offering and wait until every owed result has come
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one random unit: mostly well-formed sequences, some noise
    task automatic send_random_unit(input logic [1:0] m);
        int         pick;
        logic [7:0] cmd;
        logic [7:0] opt;
        pick = $urandom_range(99);
        if (m == MODE_TELNET && pick < 60) begin
            case ($urandom_range(7))
                0:       cmd = CMD_WILL;
                1:       cmd = CMD_WONT;
                2:       cmd = CMD_DO;
                3:       cmd = CMD_DONT;
                4:       cmd = CMD_GA;
                5:       cmd = BYTE_IAC;
                6:       cmd = CMD_SB;
                default: cmd = 8'($urandom_range(255));
            endcase
            case ($urandom_range(4))
                0:       opt = OPT_BIN;
                1:       opt = OPT_ECHO;
                2:       opt = OPT_SGA;
                default: opt = 8'($urandom_range(255));
            endcase
            send_byte(BYTE_IAC);
            send_byte(cmd);
            if (cmd != CMD_GA) send_byte(opt);
        end else if (m == MODE_ESCAPE && pick < 50) begin
            send_byte(BYTE_IAC);
            send_byte((pick < 10) ? BYTE_IAC : 8'($urandom_range(255)));
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input logic [1:0] m, input int n_bytes, input logic hold_off);
        int start;
        drain_results();
        set_mode(m);
        if (hold_off) hold_off_req++;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_random_unit(m);
    endtask

    // stimulus
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // escape mode out of reset: plain, literal 0xff, status with break
        send_byte(8'h00);
        send_byte(BYTE_IAC);
        send_byte(BYTE_IAC);
        send_byte(BYTE_IAC);
        send_byte(8'h07);

        // raw passes 0xff untouched
        drain_results();
        set_mode(MODE_RAW);
        send_byte(BYTE_IAC);

        // telnet: options, binary pass-through, unknown option, go ahead
        drain_results();
        set_mode(MODE_TELNET);
        send_byte(8'h41);
        send_byte(BYTE_IAC); send_byte(CMD_WILL); send_byte(OPT_BIN);
        send_byte(BYTE_IAC); send_byte(BYTE_IAC);
        send_byte(BYTE_IAC); send_byte(CMD_DO);   send_byte(8'h05);
        send_byte(BYTE_IAC); send_byte(CMD_DONT); send_byte(OPT_BIN);
        send_byte(BYTE_IAC); send_byte(CMD_WONT); send_byte(OPT_BIN);
        send_byte(BYTE_IAC); send_byte(BYTE_IAC); send_byte(OPT_ECHO);
        send_byte(BYTE_IAC); send_byte(CMD_GA);
        // leave an iac open across the next mode changes
        send_byte(BYTE_IAC);

        // random phases over every mode
        run_phase(MODE_ESCAPE, 50, 1'b0);
        run_phase(MODE_TELNET, 60, 1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(MODE_TELNET, 50, 1'b0);
        tx_idle_pct = 33;
        rx_idle_pct = 33;
        run_phase(MODE_RAW, 30, 1'b0);
        run_phase(MODE_SPARE, 20, 1'b0);
        run_phase(MODE_ESCAPE, 40, 1'b0);
        run_phase(MODE_TELNET, 60, 1'b0);
        drain_results();

        $display("checked %0d results from %0d bytes across raw, escape, telnet and spare modes",
                 checked, bytes_sent);
        $display("included a %0d cycle receiver hold-off and a no-idle telnet stretch",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
